@@ hdl/durf_pkg.sv @@
// Package for the dual ultrasonic ranging framer.
// Holds the command and status words between controller and datapath, and fixed constants.
// No dependencies.
package durf_pkg;

  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_TRIGGER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAP     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TPC     = 2'd3;

  localparam logic [7:0]  TRIGGER_RESET = 8'd15;
  localparam logic [19:0] TIMEOUT_RESET = 20'd30000;
  localparam logic [19:0] GAP_RESET     = 20'd40000;
  localparam logic [7:0]  TPC_RESET     = 8'd58;

  localparam logic [7:0] DIST_MAX   = 8'd254;
  localparam logic [7:0] START_BYTE = 8'hFF;

  localparam logic [1:0] SUB_TRIG = 2'd0;
  localparam logic [1:0] SUB_RISE = 2'd1;
  localparam logic [1:0] SUB_MEAS = 2'd2;
  localparam logic [1:0] SUB_GAP  = 2'd3;

  typedef struct packed {
    logic tick;
    logic div_step;
    logic div_last;
    logic load_top;
    logic load_bottom;
  } cmd_t;

  typedef struct packed {
    logic frame;
    logic div_start;
  } status_t;

endpackage

@@ hdl/durf_ctrl.sv @@
// Controller of the ranging framer: sequences ticks, the serial divide and the frame bytes.
// Depends on durf_pkg.
module durf_ctrl #(
  parameter int WIDTH_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  durf_pkg::status_t st,
  output durf_pkg::cmd_t    cmd
);
  import durf_pkg::*;

  localparam int StepW = $clog2(WIDTH_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FRAME_TOP,
    S_FRAME_BOT
  } state_t;

  state_t           state;
  logic [StepW-1:0] step;
  logic             out_free;

  always_comb begin
    out_free = !out_valid || !out_stall;
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = !out_free;
        cmd.tick = in_valid && out_free;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (step == '0);
      end
      S_FRAME_TOP: cmd.load_top = out_free;
      S_FRAME_BOT: cmd.load_bottom = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.tick || cmd.load_top || cmd.load_bottom) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.tick) begin
            if (st.frame) begin
              state <= S_FRAME_TOP;
            end else if (st.div_start) begin
              state <= S_DIV;
              step  <= StepW'(WIDTH_BITS - 1);
            end
          end
        end
        S_DIV: begin
          if (step == '0) begin
            state <= S_IDLE;
          end else begin
            step <= step - 1'b1;
          end
        end
        S_FRAME_TOP: begin
          if (cmd.load_top) begin
            state <= S_FRAME_BOT;
          end
        end
        S_FRAME_BOT: begin
          if (cmd.load_bottom) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/durf_datapath.sv @@
// Datapath of the ranging framer: configuration, phase counters, echo width, divider and word register.
// Depends on durf_pkg.
module durf_datapath #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [durf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [durf_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          echo_top,
  input  logic                          echo_bottom,
  input  durf_pkg::cmd_t                cmd,
  output durf_pkg::status_t             st,
  output logic                          trig_top,
  output logic                          trig_bottom,
  output logic                          byte_valid,
  output logic [7:0]                    frame_byte,
  output logic                          last_of_tick
);
  import durf_pkg::*;

  logic [7:0]  trigger_ticks;
  logic [19:0] timeout_ticks;
  logic [19:0] gap_ticks;
  logic [7:0]  ticks_per_cm;

  logic [2:0]            phase, phase_next;
  logic [19:0]           phase_counter, phase_counter_next;
  logic [WIDTH_BITS-1:0] echo_width, echo_width_next, width_inc;
  logic [1:0]            previous_echo;
  logic [7:0]            top_distance, top_distance_next;
  logic [7:0]            bottom_distance, bottom_distance_next;

  logic                  div_sensor;
  logic [7:0]            rem;
  logic [WIDTH_BITS-1:0] quo, quo_next;
  logic [8:0]            trial;
  logic                  take;
  logic [7:0]            rem_next;
  logic [7:0]            quotient_cm;

  logic        sensor, echo, prev, tt, tb;
  logic [1:0]  sub;
  logic [20:0] count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= TRIGGER_RESET;
      timeout_ticks <= TIMEOUT_RESET;
      gap_ticks     <= GAP_RESET;
      ticks_per_cm  <= TPC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TRIGGER: trigger_ticks <= cfg_data[7:0];
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        CFG_GAP:     gap_ticks     <= cfg_data;
        CFG_TPC:     ticks_per_cm  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sensor    = phase[2];
    sub       = phase[1:0];
    echo      = sensor ? echo_bottom : echo_top;
    prev      = previous_echo[sensor];
    count_inc = {1'b0, phase_counter} + 21'd1;
    width_inc = (echo_width == '1) ? echo_width : echo_width + 1'b1;
    tt        = 1'b0;
    tb        = 1'b0;
    st        = '0;
    phase_next           = phase;
    phase_counter_next   = phase_counter;
    echo_width_next      = echo_width;
    top_distance_next    = top_distance;
    bottom_distance_next = bottom_distance;
    case (sub)
      SUB_TRIG: begin
        tt = !sensor;
        tb = sensor;
        if (count_inc >= {13'd0, trigger_ticks}) begin
          phase_next         = {sensor, SUB_RISE};
          phase_counter_next = '0;
        end else begin
          phase_counter_next = count_inc[19:0];
        end
      end
      SUB_RISE: begin
        if (echo && !prev) begin
          echo_width_next    = '0;
          phase_next         = {sensor, SUB_MEAS};
          phase_counter_next = '0;
        end else if (phase_counter >= timeout_ticks) begin
          if (sensor) begin
            bottom_distance_next = DIST_MAX;
          end else begin
            top_distance_next = DIST_MAX;
          end
          phase_next         = {sensor, SUB_GAP};
          phase_counter_next = '0;
        end else begin
          phase_counter_next = count_inc[19:0];
        end
      end
      SUB_MEAS: begin
        echo_width_next = width_inc;
        if (!echo || phase_counter >= timeout_ticks) begin
          if (!echo && ticks_per_cm != '0) begin
            st.div_start = 1'b1;
          end else if (sensor) begin
            bottom_distance_next = DIST_MAX;
          end else begin
            top_distance_next = DIST_MAX;
          end
          phase_next         = {sensor, SUB_GAP};
          phase_counter_next = '0;
        end else begin
          phase_counter_next = count_inc[19:0];
        end
      end
      default: begin
        if (count_inc >= {1'b0, gap_ticks}) begin
          st.frame           = sensor;
          phase_next         = {!sensor, SUB_TRIG};
          phase_counter_next = '0;
        end else begin
          phase_counter_next = count_inc[19:0];
        end
      end
    endcase
  end

  always_comb begin
    trial       = {rem, quo[WIDTH_BITS-1]};
    take        = (trial >= {1'b0, ticks_per_cm});
    rem_next    = take ? 8'(trial - {1'b0, ticks_per_cm}) : trial[7:0];
    quo_next    = {quo[WIDTH_BITS-2:0], take};
    quotient_cm = (quo_next > WIDTH_BITS'(DIST_MAX)) ? DIST_MAX : quo_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= {1'b0, SUB_TRIG};
      phase_counter   <= '0;
      echo_width      <= '0;
      previous_echo   <= '0;
      top_distance    <= '0;
      bottom_distance <= '0;
    end else if (cmd.tick) begin
      phase           <= phase_next;
      phase_counter   <= phase_counter_next;
      echo_width      <= echo_width_next;
      previous_echo   <= {echo_bottom, echo_top};
      top_distance    <= top_distance_next;
      bottom_distance <= bottom_distance_next;
    end else if (cmd.div_last) begin
      if (div_sensor) begin
        bottom_distance <= quotient_cm;
      end else begin
        top_distance <= quotient_cm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick && st.div_start) begin
      div_sensor <= sensor;
      rem        <= '0;
      quo        <= width_inc;
    end else if (cmd.div_step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      trig_top     <= st.frame ? 1'b0 : tt;
      trig_bottom  <= st.frame ? 1'b0 : tb;
      byte_valid   <= st.frame;
      frame_byte   <= st.frame ? START_BYTE : 8'd0;
      last_of_tick <= !st.frame;
    end else if (cmd.load_top || cmd.load_bottom) begin
      trig_top     <= 1'b0;
      trig_bottom  <= 1'b0;
      byte_valid   <= 1'b1;
      frame_byte   <= cmd.load_top ? top_distance : bottom_distance;
      last_of_tick <= cmd.load_bottom;
    end
  end

endmodule

@@ hdl/dual_ultrasonic_ranging_framer_top.sv @@
// Top level of the dual ultrasonic ranging framer: controller and datapath joined by command words.
// Depends on durf_pkg, durf_ctrl and durf_datapath.
//
//   Channel | Handshake            | Word
//   --------+----------------------+---------------------------------------------------
//   in      | in_valid / in_stall  | echo_top, echo_bottom
//   out     | out_valid / out_stall| trig_top, trig_bottom, byte_valid, frame_byte, last_of_tick
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// An ordinary tick's word sits in the output register.
// A tick that sees an echo fall is followed by a bit-serial divide, during which no tick is taken,
// unless ticks_per_cm is zero.
// The frame tick delivers three words.
// In idle, a new tick is taken while the output word is taken or absent.
// Reset clears all control state synchronously; there is no clearing pass.
module dual_ultrasonic_ranging_framer_top #(
  parameter int WIDTH_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [durf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [durf_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          echo_top,
  input  logic                          echo_bottom,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          trig_top,
  output logic                          trig_bottom,
  output logic                          byte_valid,
  output logic [7:0]                    frame_byte,
  output logic                          last_of_tick
);
  import durf_pkg::*;

  cmd_t    cmd;
  status_t st;

  durf_ctrl #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .st       (st),
    .cmd      (cmd)
  );

  durf_datapath #(
    .WIDTH_BITS(WIDTH_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .echo_top    (echo_top),
    .echo_bottom (echo_bottom),
    .cmd         (cmd),
    .st          (st),
    .trig_top    (trig_top),
    .trig_bottom (trig_bottom),
    .byte_valid  (byte_valid),
    .frame_byte  (frame_byte),
    .last_of_tick(last_of_tick)
  );

  // A waiting word is never overwritten by a new tick.
  assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall && out_valid && out_stall))
    else $error("tick taken while the output word was stalled");

  // While a frame is being delivered, no tick is taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid && !last_of_tick) |-> in_stall)
    else $error("tick taken in the middle of a frame");

  // At most one trigger line is high in a valid output word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trig_top && trig_bottom))
    else $error("both trigger lines high");

endmodule

@@ bench/dual_ultrasonic_ranging_framer_top_tb.sv @@
// Self-checking bench for the dual ultrasonic ranging framer: ticks pass through a bursty driver,
// line words are checked against a cycle-free model of the ranging sequence kept in the bench.
// Depends on durf_pkg and dual_ultrasonic_ranging_framer_top.
module dual_ultrasonic_ranging_framer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import durf_pkg::*;

  localparam int WIDTH_BITS = 16;
  localparam logic [WIDTH_BITS-1:0] WIDTH_TOP = '1;

  typedef struct packed {
    logic top;
    logic bottom;
  } echo_pair_t;

  typedef struct packed {
    logic       trig_top;
    logic       trig_bottom;
    logic       byte_valid;
    logic [7:0] frame_byte;
    logic       last_of_tick;
  } line_word_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                echo_top = 1'b0;
  logic                echo_bottom = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                trig_top;
  logic                trig_bottom;
  logic                byte_valid;
  logic [7:0]          frame_byte;
  logic                last_of_tick;

  dual_ultrasonic_ranging_framer_top #(
    .WIDTH_BITS(WIDTH_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .echo_top(echo_top),
    .echo_bottom(echo_bottom),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .trig_top(trig_top),
    .trig_bottom(trig_bottom),
    .byte_valid(byte_valid),
    .frame_byte(frame_byte),
    .last_of_tick(last_of_tick)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  echo_pair_t ticks_waiting[$];
  line_word_t words_due[$];
  int mismatch_count = 0;

  // Shadow of the ranging sequencer and its registers.
  logic [7:0]            trig_len = TRIGGER_RESET;
  logic [19:0]           echo_limit = TIMEOUT_RESET;
  logic [19:0]           gap_len = GAP_RESET;
  logic [7:0]            cm_ticks = TPC_RESET;
  logic                  on_bottom = 1'b0;
  logic [1:0]            step_kind = SUB_TRIG;
  logic [19:0]           step_count = '0;
  logic [WIDTH_BITS-1:0] pulse_width = '0;
  echo_pair_t            last_echo = '0;
  logic [7:0]            top_cm = '0;
  logic [7:0]            bottom_cm = '0;

  function automatic void enter_step(input logic bottom, input logic [1:0] kind);
    on_bottom = bottom;
    step_kind = kind;
    step_count = '0;
  endfunction

  function automatic void keep_cm(input logic [7:0] cm);
    if (on_bottom) begin
      bottom_cm = cm;
    end else begin
      top_cm = cm;
    end
  endfunction

  function automatic void range_tick(input echo_pair_t e);
    logic        level;
    logic        was;
    logic        tt;
    logic        tb;
    logic        frame_out;
    logic [7:0]  cm;
    int unsigned quotient;
    level = on_bottom ? e.bottom : e.top;
    was = on_bottom ? last_echo.bottom : last_echo.top;
    tt = 1'b0;
    tb = 1'b0;
    frame_out = 1'b0;
    case (step_kind)
      SUB_TRIG: begin
        if (on_bottom) begin
          tb = 1'b1;
        end else begin
          tt = 1'b1;
        end
        if (21'(step_count) + 21'd1 >= 21'(trig_len)) begin
          enter_step(on_bottom, SUB_RISE);
        end else begin
          step_count++;
        end
      end
      SUB_RISE: begin
        if (level && !was) begin
          pulse_width = '0;
          enter_step(on_bottom, SUB_MEAS);
        end else if (step_count >= echo_limit) begin
          keep_cm(DIST_MAX);
          enter_step(on_bottom, SUB_GAP);
        end else begin
          step_count++;
        end
      end
      SUB_MEAS: begin
        if (pulse_width != WIDTH_TOP) pulse_width++;
        if (!level) begin
          cm = DIST_MAX;
          if (cm_ticks != 8'd0) begin
            quotient = pulse_width / cm_ticks;
            if (quotient <= DIST_MAX) cm = quotient[7:0];
          end
          keep_cm(cm);
          enter_step(on_bottom, SUB_GAP);
        end else if (step_count >= echo_limit) begin
          keep_cm(DIST_MAX);
          enter_step(on_bottom, SUB_GAP);
        end else begin
          step_count++;
        end
      end
      default: begin
        if (21'(step_count) + 21'd1 >= 21'(gap_len)) begin
          if (on_bottom) begin
            frame_out = 1'b1;
            enter_step(1'b0, SUB_TRIG);
          end else begin
            enter_step(1'b1, SUB_TRIG);
          end
        end else begin
          step_count++;
        end
      end
    endcase
    last_echo = e;
    if (frame_out) begin
      words_due.push_back(line_word_t'{1'b0, 1'b0, 1'b1, START_BYTE, 1'b0});
      words_due.push_back(line_word_t'{1'b0, 1'b0, 1'b1, top_cm, 1'b0});
      words_due.push_back(line_word_t'{1'b0, 1'b0, 1'b1, bottom_cm, 1'b1});
    end else begin
      words_due.push_back(line_word_t'{tt, tb, 1'b0, 8'd0, 1'b1});
    end
  endfunction

  // Sender: bursts of ticks separated by random rests.
  echo_pair_t offered = '0;
  int burst_left = 1;
  int rest_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) range_tick(offered);
      if (!in_valid || !in_stall) begin
        if (rest_left > 0 || ticks_waiting.size() == 0) begin
          if (rest_left > 0) rest_left--;
          in_valid <= 1'b0;
        end else begin
          offered = ticks_waiting.pop_front();
          in_valid <= 1'b1;
          echo_top <= offered.top;
          echo_bottom <= offered.bottom;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            rest_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // Receiver: checks each taken word and stalls in changing styles.
  stall_mode_t stall_style = STALL_NONE;
  int stall_clock = 0;

  function automatic void check_field(input string field, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    line_word_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          $display("%0t ns: expected no word, actual trig %b%b valid %b byte %0d last %b",
                   $time, trig_top, trig_bottom, byte_valid, frame_byte, last_of_tick);
          mismatch_count++;
        end else begin
          want = words_due.pop_front();
          check_field("trig_top", want.trig_top, trig_top);
          check_field("trig_bottom", want.trig_bottom, trig_bottom);
          check_field("byte_valid", want.byte_valid, byte_valid);
          check_field("frame_byte", want.frame_byte, frame_byte);
          check_field("last_of_tick", want.last_of_tick, last_of_tick);
        end
      end
      stall_clock++;
      if (stall_clock % 64 == 0) stall_style = stall_mode_t'($urandom_range(0, 3));
      case (stall_style)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (stall_clock % 5 < 2);
      endcase
    end
  end

  task automatic push_ticks(input logic top, input logic bottom, input int count);
    repeat (count) ticks_waiting.push_back(echo_pair_t'{top, bottom});
  endtask

  // Independent pulse trains on both lines, with the odd tick of noise.
  task automatic pulse_trains(input int count, input int max_run);
    echo_pair_t e;
    int         top_run;
    int         bottom_run;
    e = echo_pair_t'($urandom_range(0, 3));
    top_run = $urandom_range(1, max_run);
    bottom_run = $urandom_range(1, max_run);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) begin
        ticks_waiting.push_back(echo_pair_t'($urandom_range(0, 3)));
      end else begin
        ticks_waiting.push_back(e);
      end
      top_run--;
      bottom_run--;
      if (top_run == 0) begin
        e.top = !e.top;
        top_run = $urandom_range(1, max_run);
      end
      if (bottom_run == 0) begin
        e.bottom = !e.bottom;
        bottom_run = $urandom_range(1, max_run);
      end
    end
  endtask

  // The block is idle once every word is out and it takes ticks again, so any divide is done.
  task automatic settle();
    do @(negedge clk);
    while (ticks_waiting.size() != 0 || in_valid || words_due.size() != 0 || in_stall);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic write_setting(input logic [7:0] t, input logic [19:0] lim,
                               input logic [19:0] g, input logic [7:0] c);
    write_reg(CFG_TRIGGER, {12'd0, t});
    write_reg(CFG_TIMEOUT, lim);
    write_reg(CFG_GAP, g);
    write_reg(CFG_TPC, {12'd0, c});
    @(posedge clk);
    cfg_we <= 1'b0;
    trig_len = t;
    echo_limit = lim;
    gap_len = g;
    cm_ticks = c;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the top trigger is still running throughout.
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b0, 1'b0, 1);
    push_ticks(1'b1, 1'b0, 1);
    push_ticks(1'b0, 1'b1, 1);
    settle();

    // Zero trigger and gap lengths, zero ticks per centimetre, both kinds of timeout,
    // a line already high when the wait for its rising edge begins, and two frames.
    write_setting(8'd0, 20'd2, 20'd0, 8'd0);
    push_ticks(1'b1, 1'b0, 2);
    push_ticks(1'b0, 1'b0, 1);
    push_ticks(1'b1, 1'b1, 1);
    push_ticks(1'b1, 1'b0, 1);
    push_ticks(1'b0, 1'b0, 1);
    push_ticks(1'b0, 1'b1, 5);
    push_ticks(1'b0, 1'b0, 2);
    push_ticks(1'b1, 1'b0, 4);
    push_ticks(1'b0, 1'b0, 2);
    push_ticks(1'b0, 1'b1, 1);
    push_ticks(1'b0, 1'b0, 2);
    settle();

    write_setting(8'd1, 20'd1, 20'd0, 8'd1);
    pulse_trains(15, 4);
    settle();
    write_setting(8'd3, 20'd12, 20'd2, 8'd3);
    pulse_trains(15, 10);
    settle();
    write_setting(8'd255, 20'hFFFFF, 20'hFFFFF, 8'd255);
    pulse_trains(10, 8);
    settle();
    write_setting(8'd2, 20'd1, 20'd1, 8'd255);
    pulse_trains(15, 3);
    settle();

    // A top echo long enough that the distance saturates at its ceiling.
    write_setting(8'd1, 20'd400, 20'd0, 8'd1);
    push_ticks(1'b0, 1'b0, 4);
    push_ticks(1'b0, 1'b1, 3);
    push_ticks(1'b0, 1'b0, 3);
    push_ticks(1'b1, 1'b0, 270);
    push_ticks(1'b0, 1'b0, 6);
    pulse_trains(10, 6);
    settle();

    write_setting(8'd5, 20'd30, 20'd4, 8'd2);
    pulse_trains(20, 20);
    settle();
    repeat (2) begin
      write_setting(8'($urandom_range(1, 8)), 20'($urandom_range(1, 40)),
                    20'($urandom_range(0, 6)), 8'($urandom_range(1, 16)));
      pulse_trains(10, $urandom_range(2, 25));
      settle();
    end

    repeat (40) @(posedge clk);
    if (words_due.size() != 0) begin
      $display("%0t ns: expected %0d more words, actual none", $time, words_due.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
